// ===== rtl/lcc_pkg.sv =====
// Shared constants and types for the Log3G10 encode/decode pipeline.
// Holds the fixed-point curve coefficients, the pipeline depth and the CSR decode.
// No dependencies.
`default_nettype none

package lcc_pkg;

   localparam int unsigned DEPTH = 36;

   typedef logic [DEPTH-1:0] stage_vec_type;

   localparam logic [9:0]  C_Q16     = 10'd655;
   localparam logic [19:0] G_Q16     = 20'd995669;
   localparam logic [18:0] G_HALF    = 19'd497834;
   localparam logic [23:0] B_Q16     = 24'd10221999;
   localparam logic [22:0] B_HALF    = 23'd5110999;
   localparam logic [28:0] ALOG2_Q32 = 29'd289977335;
   localparam logic [19:0] L10A_Q16  = 20'd970679;
   localparam logic [31:0] LN2_Q32   = 32'd2977044472;

   localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   // Reciprocals ceil(2^34 / n), exact floor division for 30-bit dividends.
   localparam logic [34:0] RECIP_Q34 [1:14] = '{
      35'd17179869184, 35'd8589934592, 35'd5726623062, 35'd4294967296,
      35'd3435973837,  35'd2863311531, 35'd2454267027, 35'd2147483648,
      35'd1908874354,  35'd1717986919, 35'd1561806290, 35'd1431655766,
      35'd1321528399,  35'd1227133514
   };

   // Floor reciprocals of b and g; the estimated quotient is at most one below the true one.
   localparam int unsigned RECIP_B_SHIFT = 55;
   localparam int unsigned RECIP_G_SHIFT = 51;
   localparam logic [31:0] RECIP_B = 32'((64'd1 << RECIP_B_SHIFT) / 64'(B_Q16));
   localparam logic [31:0] RECIP_G = 32'((64'd1 << RECIP_G_SHIFT) / 64'(G_Q16));

   localparam int unsigned ADDR_W = 3;
   localparam logic REG_INVERSE_MODE = 1'b0;

endpackage

`default_nettype wire

// ===== rtl/lcc_pipe_ctrl.sv =====
// Beat control for the conversion pipeline: per-stage valid bits and load enables.
// A stage loads when it is empty or its successor loads, so bubbles collapse.
// Depends on lcc_pkg.
`default_nettype none

module lcc_pipe_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output lcc_pkg::stage_vec_type      en
);
   import lcc_pkg::*;

   stage_vec_type   valid_ff;
   stage_vec_type   valid_in;
   logic [DEPTH:0]  rdy;

   assign rdy[DEPTH] = rsp_ready;

   for (genvar k = 0; k < DEPTH; k++) begin : g_stage
      assign rdy[k] = !valid_ff[k] || rdy[k+1];
      if (k == 0) begin : g_first
         assign valid_in[k] = rdy[k] ? req_valid : valid_ff[k];
      end else begin : g_rest
         assign valid_in[k] = rdy[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign en        = rdy[DEPTH-1:0];
   assign req_ready = rdy[0];
   assign rsp_valid = valid_ff[DEPTH-1];

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> valid_ff[0])
      else $error("accepted beat did not enter the first stage");

   a_free_when_open: assert property (@(posedge clock) disable iff (reset)
      (!valid_ff[DEPTH-1] || rsp_ready) |-> req_ready)
      else $error("input stalled while the output side was open");

   a_beat_count: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ($countones(valid_ff) == $past($countones(valid_ff))
         + $past(req_valid && req_ready) - $past(rsp_valid && rsp_ready)))
      else $error("beat lost or duplicated inside the pipeline");

endmodule

`default_nettype wire

// ===== rtl/lcc_log_path.sv =====
// Forward data path: linear sample to Log3G10 code, one stage per load enable.
// Multiply, normalize, 24 squaring steps for log2, scale and round; then delay taps.
// Depends on lcc_pkg.
`default_nettype none

module lcc_log_path (
   input  wire logic                  clock,
   input  wire lcc_pkg::stage_vec_type en,
   input  wire logic signed [31:0]    sample_in,
   output logic signed [31:0]         sample_out
);
   import lcc_pkg::*;

   typedef struct packed {
      logic        neg;
      logic [31:0] res;
      logic [57:0] wide;
      logic [5:0]  msb;
      logic [30:0] mant;
      logic [4:0]  rint;
      logic [23:0] frac;
   } log_stage_type;

   log_stage_type stg_ff [DEPTH];
   log_stage_type stg_in [DEPTH];

   function automatic logic [5:0] msb_pos(input logic [55:0] v);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < 56; i++) begin
         if (v[i]) begin
            p = 6'(i);
         end
      end
      return p;
   endfunction

   for (genvar k = 0; k < DEPTH; k++) begin : g_stage
      if (k == 0) begin : g_prep
         always_comb begin
            logic [32:0] s_sum;
            logic [31:0] a;
            logic [23:0] b;
            logic [55:0] p;
            s_sum = {sample_in[31], sample_in} + 33'(C_Q16);
            a = s_sum[32] ? 32'(~s_sum + 33'd1) : s_sum[31:0];
            b = s_sum[32] ? 24'(G_Q16) : B_Q16;
            p = 56'(a) * 56'(b);
            stg_in[k]      = '0;
            stg_in[k].neg  = s_sum[32];
            stg_in[k].wide = {2'b00, p};
         end
      end else if (k == 1) begin : g_norm
         always_comb begin
            logic [55:0] rnd;
            logic [39:0] mag;
            logic [55:0] v;
            stg_in[k] = stg_ff[k-1];
            rnd = stg_ff[k-1].wide[55:0] + 56'd32768;
            mag = rnd[55:16];
            v   = stg_ff[k-1].wide[55:0] + (56'd1 << 32);
            if (stg_ff[k-1].neg) begin
               stg_in[k].res = (mag > 40'h80000000) ? SAT_MIN : (~mag[31:0] + 32'd1);
            end else begin
               stg_in[k].wide = {2'b00, v};
               stg_in[k].msb  = msb_pos(v);
            end
         end
      end else if (k == 2) begin : g_shift
         always_comb begin
            logic [5:0]  sh;
            logic [55:0] sv;
            stg_in[k] = stg_ff[k-1];
            sh = stg_ff[k-1].msb - 6'd30;
            sv = stg_ff[k-1].wide[55:0] >> sh;
            stg_in[k].mant = sv[30:0];
            stg_in[k].rint = 5'(stg_ff[k-1].msb - 6'd32);
         end
      end else if (k <= 26) begin : g_square
         always_comb begin
            logic [61:0] sq;
            logic [31:0] s32;
            stg_in[k] = stg_ff[k-1];
            sq  = 62'(stg_ff[k-1].mant) * 62'(stg_ff[k-1].mant);
            s32 = sq[61:30];
            stg_in[k].mant = s32[31] ? s32[31:1] : s32[30:0];
            stg_in[k].frac = {stg_ff[k-1].frac[22:0], s32[31]};
         end
      end else if (k == 27) begin : g_scale
         always_comb begin
            stg_in[k] = stg_ff[k-1];
            stg_in[k].wide = 58'({stg_ff[k-1].rint, stg_ff[k-1].frac}) * 58'(ALOG2_Q32);
         end
      end else if (k == 28) begin : g_round
         always_comb begin
            logic [57:0] rnd;
            stg_in[k] = stg_ff[k-1];
            rnd = stg_ff[k-1].wide + (58'd1 << 39);
            if (!stg_ff[k-1].neg) begin
               stg_in[k].res = {14'b0, rnd[57:40]};
            end
         end
      end else begin : g_delay
         assign stg_in[k] = stg_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   assign sample_out = stg_ff[DEPTH-1].res;

endmodule

`default_nettype wire

// ===== rtl/lcc_exp_path.sv =====
// Inverse data path: Log3G10 code to linear sample, one stage per load enable.
// Exponent split, 14-term Taylor series for 2^f, then reciprocal division by g or b.
// Depends on lcc_pkg.
`default_nettype none

module lcc_exp_path (
   input  wire logic                  clock,
   input  wire lcc_pkg::stage_vec_type en,
   input  wire logic signed [31:0]    sample_in,
   output logic signed [31:0]         sample_out
);
   import lcc_pkg::*;

   typedef struct packed {
      logic        neg;
      logic        sat;
      logic [4:0]  ip;
      logic [29:0] z;
      logic [30:0] term;
      logic [30:0] sum;
      logic [29:0] t;
      logic [55:0] rem;
      logic [59:0] p_hi;
      logic [59:0] p_lo;
      logic [31:0] quo;
      logic [31:0] res;
   } exp_stage_type;

   exp_stage_type stg_ff [DEPTH];
   exp_stage_type stg_in [DEPTH];

   for (genvar k = 0; k < DEPTH; k++) begin : g_stage
      if (k == 0) begin : g_prep
         always_comb begin
            logic [31:0] mag;
            mag = sample_in[31] ? (~sample_in + 32'd1) : sample_in;
            stg_in[k]     = '0;
            stg_in[k].neg = sample_in[31];
            stg_in[k].rem = sample_in[31] ? ((56'(mag) << 16) + 56'(G_HALF))
                                          : (56'(mag) * 56'(L10A_Q16));
         end
      end else if (k == 1) begin : g_split
         always_comb begin
            logic [18:0] ip_full;
            logic [63:0] zp;
            stg_in[k] = stg_ff[k-1];
            ip_full = stg_ff[k-1].rem[50:32];
            zp = 64'(stg_ff[k-1].rem[31:0]) * 64'(LN2_Q32);
            stg_in[k].term = 31'd1 << 30;
            stg_in[k].sum  = 31'd1 << 30;
            if (!stg_ff[k-1].neg) begin
               stg_in[k].z   = zp[63:34];
               stg_in[k].ip  = ip_full[4:0];
               stg_in[k].sat = ip_full > 19'd22;
            end
         end
      end else if (k <= 29) begin : g_taylor
         localparam int unsigned N = (k - 2) / 2 + 1;
         if (((k - 2) % 2) == 0) begin : g_mul
            always_comb begin
               logic [60:0] pr;
               stg_in[k] = stg_ff[k-1];
               pr = 61'(stg_ff[k-1].term) * 61'(stg_ff[k-1].z);
               stg_in[k].t = pr[59:30];
            end
         end else begin : g_div
            always_comb begin
               logic [64:0] pr;
               stg_in[k] = stg_ff[k-1];
               pr = 65'(stg_ff[k-1].t) * 65'(RECIP_Q34[N]);
               stg_in[k].term = {1'b0, pr[63:34]};
               stg_in[k].sum  = stg_ff[k-1].sum + {1'b0, pr[63:34]};
            end
         end
      end else if (k == 30) begin : g_scale
         always_comb begin
            logic [55:0] p;
            stg_in[k] = stg_ff[k-1];
            p = 56'(stg_ff[k-1].sum) << stg_ff[k-1].ip;
            if (!stg_ff[k-1].neg) begin
               stg_in[k].rem = ((p - (56'd1 << 30)) << 2) + 56'(B_HALF);
            end
         end
      end else if (k == 31) begin : g_recip
         always_comb begin
            logic [31:0] r;
            stg_in[k] = stg_ff[k-1];
            r = stg_ff[k-1].neg ? RECIP_G : RECIP_B;
            stg_in[k].p_hi = 60'(stg_ff[k-1].rem[55:28]) * 60'(r);
            stg_in[k].p_lo = 60'(stg_ff[k-1].rem[27:0]) * 60'(r);
         end
      end else if (k == 32) begin : g_estimate
         always_comb begin
            logic [87:0] full;
            stg_in[k] = stg_ff[k-1];
            full = (88'(stg_ff[k-1].p_hi) << 28) + 88'(stg_ff[k-1].p_lo);
            stg_in[k].quo = stg_ff[k-1].neg ? full[RECIP_G_SHIFT +: 32]
                                            : full[RECIP_B_SHIFT +: 32];
         end
      end else if (k == 33) begin : g_residue
         always_comb begin
            logic [23:0] d;
            stg_in[k] = stg_ff[k-1];
            d = stg_ff[k-1].neg ? 24'(G_Q16) : B_Q16;
            stg_in[k].rem = stg_ff[k-1].rem - 56'(stg_ff[k-1].quo) * 56'(d);
         end
      end else if (k == 34) begin : g_correct
         always_comb begin
            logic [23:0] d;
            stg_in[k] = stg_ff[k-1];
            d = stg_ff[k-1].neg ? 24'(G_Q16) : B_Q16;
            if (stg_ff[k-1].rem >= 56'(d)) begin
               stg_in[k].rem = stg_ff[k-1].rem - 56'(d);
               stg_in[k].quo = stg_ff[k-1].quo + 32'd1;
            end
         end
      end else begin : g_final
         always_comb begin
            logic signed [33:0] q;
            logic signed [33:0] val;
            stg_in[k] = stg_ff[k-1];
            q   = $signed({2'b00, stg_ff[k-1].quo});
            val = stg_ff[k-1].neg ? (-q - 34'sd655) : (q - 34'sd655);
            if (stg_ff[k-1].sat || val > 34'sh0_7FFF_FFFF) begin
               stg_in[k].res = SAT_MAX;
            end else if (val < -34'sh0_8000_0000) begin
               stg_in[k].res = SAT_MIN;
            end else begin
               stg_in[k].res = val[31:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   assign sample_out = stg_ff[DEPTH-1].res;

endmodule

`default_nettype wire

// ===== rtl/log_curve_encode_decode.sv =====
// Top level of the Log3G10 encode/decode block: CSR, beat control and both data paths.
// Depends on lcc_pkg, lcc_pipe_ctrl, lcc_log_path and lcc_exp_path.
//
//   Port group   Direction  Contents
//   req_*        in         one signed Q16.16 sample per beat
//   rsp_*        out        one converted Q16.16 sample per beat
//   psel..pready APB        inverse_mode at byte address 0
//
// One beat enters per clock unless every stage is full and the output is stalled;
// results pass through 36 register stages (the 14 Taylor terms take 28 of them).
// Reset clears the stage valid bits and inverse_mode; no memory needs clearing.
// A stalled output holds each full stage with no empty one after it; empty ones load.
`default_nettype none

module log_curve_encode_decode (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [31:0]           req_sample_in,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [31:0]                rsp_sample_out,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [lcc_pkg::ADDR_W-1:0]   paddr,
   input  wire logic [31:0]                  pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import lcc_pkg::*;

   logic            mode_ff;
   logic            mode_in;
   stage_vec_type   en;
   logic [31:0]     log_res;
   logic [31:0]     exp_res;

   assign pready  = 1'b1;
   assign mode_in = (psel && penable && pwrite && paddr[2] == REG_INVERSE_MODE)
                    ? pwdata[0] : mode_ff;
   assign prdata  = (paddr[2] == REG_INVERSE_MODE) ? {31'b0, mode_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   lcc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .en        (en)
   );

   lcc_log_path u_log (
      .clock      (clock),
      .en         (en),
      .sample_in  (req_sample_in),
      .sample_out (log_res)
   );

   lcc_exp_path u_exp (
      .clock      (clock),
      .en         (en),
      .sample_in  (req_sample_in),
      .sample_out (exp_res)
   );

   assign rsp_sample_out = mode_ff ? exp_res : log_res;

endmodule

`default_nettype wire

// ===== bench/log_curve_encode_decode_tb.sv =====
// Self-checking testbench for log_curve_encode_decode, the Log3G10 encode/decode block.
// It predicts every converted sample in fixed point and compares it as each beat arrives.
// Depends on lcc_pkg and the RTL top level only.
`timescale 1ns / 100ps

module log_curve_encode_decode_tb;
   import lcc_pkg::*;

   localparam logic [ADDR_W-1:0] ADDR_INVERSE_MODE = ADDR_W'(4 * REG_INVERSE_MODE);
   localparam logic [ADDR_W-1:0] ADDR_UNMAPPED     = ADDR_W'(4);
   localparam int DRAIN_CYCLES   = 80;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 300;

   localparam longint unsigned CURVE_C    = 655;
   localparam longint unsigned CURVE_G    = 995669;
   localparam longint unsigned CURVE_B    = 10221999;
   localparam longint unsigned A_LOG10_2  = 289977335;
   localparam longint unsigned LOG2_10_A  = 970679;
   localparam longint unsigned LN2_Q32V   = 64'd2977044472;
   localparam longint unsigned ONE_Q30    = 64'd1 << 30;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [31:0] req_sample_in;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [31:0] rsp_sample_out;
   logic psel;
   logic penable;
   logic pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   logic signed [31:0] pending_samples[$];
   logic signed [31:0] expected_samples[$];
   bit  inverse_sel;
   int  send_idle_pct;
   int  recv_stall_pct;
   int  hold_requests;
   int  hold_grants;
   int  hold_left;
   int  mismatches;
   int  beats_in;
   int  beats_out;
   int  quiet_cycles;
   int  neg_forward;
   int  sat_results;

   log_curve_encode_decode DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_sample_in(req_sample_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_sample_out(rsp_sample_out),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   function automatic longint clamp_q16(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned log2_q24(longint unsigned v);
      int msb;
      longint unsigned m;
      longint unsigned r;
      msb = 63;
      while (msb > 0 && v[msb] == 1'b0) msb--;
      m = v >> (msb - 30);
      r = longint'(msb - 32) << 24;
      for (int i = 23; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (ONE_Q30 << 1)) begin
            m = m >> 1;
            r = r | (64'd1 << i);
         end
      end
      return r;
   endfunction

   function automatic longint unsigned exp2_frac_q30(longint unsigned f);
      longint unsigned z;
      longint unsigned term;
      longint unsigned sum;
      z = (f * LN2_Q32V) >> 34;
      term = ONE_Q30;
      sum = ONE_Q30;
      for (int n = 1; n <= 14; n++) begin
         term = ((term * z) >> 30) / n;
         sum += term;
      end
      return sum;
   endfunction

   function automatic logic signed [31:0] convert_sample(logic signed [31:0] x_in, bit inv);
      longint x;
      longint s;
      longint unsigned mag;
      longint unsigned e;
      longint unsigned ip;
      longint unsigned p;
      longint unsigned q;
      longint y;
      x = x_in;
      if (!inv) begin
         s = x + longint'(CURVE_C);
         if (s < 0) begin
            mag = (longint'(-s) * CURVE_G + 32768) >> 16;
            y = clamp_q16(-longint'(mag));
         end else begin
            mag = log2_q24(longint'(s) * CURVE_B + (64'd1 << 32));
            y = clamp_q16(longint'((mag * A_LOG10_2 + (64'd1 << 39)) >> 40));
         end
      end else if (x < 0) begin
         mag = ((longint'(-x) << 16) + CURVE_G / 2) / CURVE_G;
         y = clamp_q16(-longint'(mag) - longint'(CURVE_C));
      end else begin
         e = longint'(x) * LOG2_10_A;
         ip = e >> 32;
         if (ip >= 23) begin
            y = 64'sd2147483647;
         end else begin
            p = exp2_frac_q30(e & 64'hFFFF_FFFF) << ip;
            q = ((p - ONE_Q30) * 4 + CURVE_B / 2) / CURVE_B;
            y = clamp_q16(longint'(q) - longint'(CURVE_C));
         end
      end
      return y[31:0];
   endfunction

   function automatic logic signed [31:0] random_sample();
      case ($urandom_range(4))
         0: return $urandom;
         1: return $urandom_range(0, 1 << 20);
         2: return -$signed($urandom_range(0, 1 << 18));
         3: return $urandom_range(0, 120000);
         default: return $urandom_range(0, 2000) - 1000;
      endcase
   endfunction

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_sample_in <= '0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            expected_samples.push_back(convert_sample(req_sample_in, inverse_sel));
            beats_in++;
            if (!inverse_sel && (longint'(req_sample_in) + longint'(CURVE_C) < 0)) begin
               neg_forward++;
            end
         end
         if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_sample_in <= pending_samples.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      logic signed [31:0] want;
      if (reset) begin
         rsp_ready <= 1'b1;
         hold_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            beats_out++;
            if (expected_samples.size() == 0) begin
               $error("sample_out: unexpected beat, actual %0d", rsp_sample_out);
               mismatches++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample_out !== want) begin
                  $error("sample_out mismatch: expected %0d, actual %0d", want, rsp_sample_out);
                  mismatches++;
               end
               if (want == 32'sh7FFF_FFFF || want == 32'sh8000_0000) sat_results++;
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (hold_grants != hold_requests) begin
            hold_grants <= hold_requests;
            hold_left <= LONG_HOLD;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic wait_drained();
      while (pending_samples.size() > 0 || req_valid || expected_samples.size() > 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_INVERSE_MODE) inverse_sel = data[0];
      @(posedge clock);
   endtask

   task automatic directed_set();
      logic signed [31:0] picks[$];
      picks = '{32'sh0000_0000, 32'sh0000_0001, -32'sd1, -32'sd655, -32'sd656,
                -32'sd654, 32'sh0001_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                32'sh5555_5555, 32'shAAAA_AAAA, 32'sd101770, 32'sd101771,
                32'sd110000, -32'sd65536, 32'sh0000_4000};
      foreach (picks[i]) pending_samples.push_back(picks[i]);
   endtask

   task automatic random_set(int count);
      repeat (count) pending_samples.push_back(random_sample());
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_in = '0;
      rsp_ready = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      inverse_sel = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_requests = 0;
      hold_grants = 0;
      hold_left = 0;
      mismatches = 0;
      beats_in = 0;
      beats_out = 0;
      quiet_cycles = 0;
      neg_forward = 0;
      sat_results = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed_set();
      wait_drained();
      csr_write(ADDR_INVERSE_MODE, 32'hFFFF_FFFF);
      directed_set();
      wait_drained();
      csr_write(ADDR_INVERSE_MODE, 32'hFFFF_FFFE);
      csr_write(ADDR_UNMAPPED, 32'h0000_0001);

      random_set(120);
      wait_drained();
      csr_write(ADDR_INVERSE_MODE, 32'h0000_0001);
      send_idle_pct = 64;
      random_set(120);
      wait_drained();
      csr_write(ADDR_INVERSE_MODE, 32'h0000_0000);
      send_idle_pct = 0;
      recv_stall_pct = 64;
      random_set(120);
      wait_drained();
      csr_write(ADDR_INVERSE_MODE, 32'h0000_0003);
      send_idle_pct = 37;
      recv_stall_pct = 37;
      random_set(120);
      wait_drained();

      // The output holds off while samples keep coming, so the pipeline backs up.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_requests = hold_requests + 1;
      random_set(140);
      wait_drained();

      $display("Covered %0d beats in, %0d beats out, %0d negative forward sums, %0d saturated.",
               beats_in, beats_out, neg_forward, sat_results);
      if (mismatches == 0 && expected_samples.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
